FILE: rtl/ucbs_pkg.sv
package ucbs_pkg;

    localparam int COORD_BITS     = 10;
    localparam int MAX_STEP_SHIFT = 5;
    localparam int RESET_SHIFT    = 5;

    // sample index runs 0..2^k inclusive
    localparam int IDX_W  = MAX_STEP_SHIFT + 1;
    localparam int SHF_W  = 3;
    // weights sum to 6*N^3
    localparam int WT_W   = 3 * MAX_STEP_SHIFT + 3;
    localparam int PROD_W = COORD_BITS + WT_W;
    localparam int ACC_W  = COORD_BITS + WT_W;
    // (acc + 3N^3) >> 3k stays below 6*2^COORD_BITS
    localparam int V_W    = COORD_BITS + 3;
    localparam int Q_W    = COORD_BITS + 1;

    // reciprocal of 6 for the final divide
    localparam int RECIP_S = V_W + 3;
    localparam int RECIP_W = RECIP_S - 2;
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((64'd1 << RECIP_S) / 64'd6);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_STEP_SHIFT = 1'b0;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  new_curve;
    } point_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] curve_x;
        logic [COORD_BITS-1:0] curve_y;
        logic                  last;
    } sample_t;

    typedef struct packed {
        logic             store;
        logic [1:0]       store_idx;
        logic             start;
        logic             issue;
        logic [IDX_W-1:0] idx;
        logic             last;
    } ucbs_cmd_t;

    typedef struct packed {
        logic adv;
        logic busy;
    } ucbs_stat_t;

endpackage

FILE: rtl/ucbs_datapath.sv
module ucbs_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ucbs_pkg::point_t     in_data,
    input  logic [2:0]           k_eff,
    input  ucbs_pkg::ucbs_cmd_t  cmd,
    output ucbs_pkg::ucbs_stat_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ucbs_pkg::sample_t    m_data
);
    import ucbs_pkg::*;

    localparam int SW = WT_W + 3;

    logic [COORD_BITS-1:0] win_x_reg [3];
    logic [COORD_BITS-1:0] win_y_reg [3];
    logic [COORD_BITS-1:0] seg_x_reg [4];
    logic [COORD_BITS-1:0] seg_y_reg [4];

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg, l5_reg, l6_reg;

    logic [IDX_W-1:0]   i1_reg, i2s_reg;
    logic [2*IDX_W-1:0] sq1_reg, sq2_reg;
    logic [3*IDX_W-1:0] cube2_reg;
    logic [WT_W-1:0]    w_reg [4];
    logic [PROD_W-1:0]  px_reg [4];
    logic [PROD_W-1:0]  py_reg [4];
    logic [V_W-1:0]     vx5_reg, vy5_reg, vx6_reg, vy6_reg;
    logic [Q_W-1:0]     qx6_reg, qy6_reg;
    sample_t            out_reg;

    logic [3:0]    sh2, sh3;
    logic [SW-1:0] t3, ni2, n2i, n3, b0, b1, b2;
    logic [ACC_W-1:0] n3_acc, accx, accy, shx, shy;
    logic [V_W+RECIP_W-1:0] mulx, muly;
    logic [V_W-1:0] rx, ry;
    logic [Q_W-1:0] qx, qy;

    assign adv  = !out_valid_reg || m_ready;
    assign stat = '{adv: adv,
                    busy: v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | v6_reg};

    assign sh2 = {k_eff, 1'b0};
    assign sh3 = {k_eff, 1'b0} + {1'b0, k_eff};

    // point window and the four points of the running segment
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            win_x_reg[cmd.store_idx] <= in_data.point_x;
            win_y_reg[cmd.store_idx] <= in_data.point_y;
        end else if (cmd.start) begin
            for (int j = 0; j < 3; j++) begin
                seg_x_reg[j] <= win_x_reg[j];
                seg_y_reg[j] <= win_y_reg[j];
            end
            seg_x_reg[3] <= in_data.point_x;
            seg_y_reg[3] <= in_data.point_y;
            win_x_reg[0] <= win_x_reg[1];
            win_x_reg[1] <= win_x_reg[2];
            win_x_reg[2] <= in_data.point_x;
            win_y_reg[0] <= win_y_reg[1];
            win_y_reg[1] <= win_y_reg[2];
            win_y_reg[2] <= in_data.point_y;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    // weights: b3 = i^3, b1/b2 from the basis, b0 from the partition of unity
    always_comb begin
        t3  = SW'(cube2_reg);
        ni2 = SW'(sq2_reg) << k_eff;
        n2i = SW'(i2s_reg) << sh2;
        n3  = SW'(1) << sh3;
        b1  = SW'(3) * t3 - SW'(6) * ni2 + SW'(4) * n3;
        b2  = n3 + SW'(3) * n2i + SW'(3) * ni2 - SW'(3) * t3;
        b0  = SW'(6) * n3 - b1 - b2 - t3;
    end

    always_comb begin
        n3_acc = ACC_W'(1) << sh3;
        accx = px_reg[0] + px_reg[1] + px_reg[2] + px_reg[3] + SW'(3) * n3_acc;
        accy = py_reg[0] + py_reg[1] + py_reg[2] + py_reg[3] + SW'(3) * n3_acc;
        shx  = accx >> sh3;
        shy  = accy >> sh3;
        mulx = (V_W+RECIP_W)'(vx5_reg) * (V_W+RECIP_W)'(RECIP_6);
        muly = (V_W+RECIP_W)'(vy5_reg) * (V_W+RECIP_W)'(RECIP_6);
        // quotient estimate is at most one low
        rx   = vx6_reg - V_W'(qx6_reg) * V_W'(6);
        ry   = vy6_reg - V_W'(qy6_reg) * V_W'(6);
        qx   = (rx >= V_W'(6)) ? qx6_reg + Q_W'(1) : qx6_reg;
        qy   = (ry >= V_W'(6)) ? qy6_reg + Q_W'(1) : qy6_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i1_reg    <= cmd.idx;
            sq1_reg   <= (2*IDX_W)'(cmd.idx) * (2*IDX_W)'(cmd.idx);
            l1_reg    <= cmd.last;

            i2s_reg   <= i1_reg;
            sq2_reg   <= sq1_reg;
            cube2_reg <= (3*IDX_W)'(sq1_reg) * (3*IDX_W)'(i1_reg);
            l2_reg    <= l1_reg;

            w_reg[0]  <= WT_W'(b0);
            w_reg[1]  <= WT_W'(b1);
            w_reg[2]  <= WT_W'(b2);
            w_reg[3]  <= WT_W'(t3);
            l3_reg    <= l2_reg;

            for (int j = 0; j < 4; j++) begin
                px_reg[j] <= PROD_W'(seg_x_reg[j]) * PROD_W'(w_reg[j]);
                py_reg[j] <= PROD_W'(seg_y_reg[j]) * PROD_W'(w_reg[j]);
            end
            l4_reg    <= l3_reg;

            vx5_reg   <= V_W'(shx);
            vy5_reg   <= V_W'(shy);
            l5_reg    <= l4_reg;

            vx6_reg   <= vx5_reg;
            vy6_reg   <= vy5_reg;
            qx6_reg   <= Q_W'(mulx >> RECIP_S);
            qy6_reg   <= Q_W'(muly >> RECIP_S);
            l6_reg    <= l5_reg;

            out_reg.curve_x <= qx[COORD_BITS-1:0];
            out_reg.curve_y <= qy[COORD_BITS-1:0];
            out_reg.last    <= l6_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/ucbs_ctrl.sv
module ucbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 new_curve,
    input  logic [2:0]           k_eff,
    input  ucbs_pkg::ucbs_stat_t stat,
    output ucbs_pkg::ucbs_cmd_t  cmd
);
    import ucbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       held_reg, held_next, held_eff;
    logic [IDX_W-1:0] idx_reg, idx_next, n_last;
    logic             accept;

    assign n_last  = IDX_W'(1) << k_eff;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign held_eff = new_curve ? 2'd0 : held_reg;

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.store_idx = held_eff;
        cmd.idx       = idx_reg;
        cmd.last      = (idx_reg == n_last);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (held_eff != 2'd3) begin
                        cmd.store = 1'b1;
                        held_next = held_eff + 2'd1;
                    end else begin
                        cmd.start  = 1'b1;
                        held_next  = held_eff;
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (stat.adv) begin
                    cmd.issue = 1'b1;
                    if (idx_reg == n_last) begin
                        state_next = ST_DRAIN;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                // segment points stay put until the last sample is past the products
                if (!stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_reg  <= 2'd0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: rtl/uniform_cubic_bspline_evaluator_core.sv
// Uniform cubic B-spline evaluator. Control points arrive one word at a time; the
// first three of a curve (or after new_curve) only fill the window. Every further
// point emits one segment of 2^k+1 samples, k being step_shift clamped to 1..5,
// with last set on the final sample. Samples are issued into a seven-stage
// arithmetic pipeline at one per cycle while the output is not stalled. No new
// point is taken until the segment has been issued and has drained from the
// pipeline stages ahead of the output register.
// step_shift lives at address 0 of the APB port and must only be written while the
// block is idle.
module uniform_cubic_bspline_evaluator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ucbs_pkg::point_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ucbs_pkg::sample_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ucbs_pkg::APB_AW-1:0]   paddr,
    input  logic [ucbs_pkg::APB_DW-1:0]   pwdata,
    output logic [ucbs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import ucbs_pkg::*;

    logic [SHF_W-1:0] step_shift_reg;
    logic [2:0]       k_eff;
    ucbs_cmd_t        cmd;
    ucbs_stat_t       stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_shift_reg <= SHF_W'(RESET_SHIFT);
        end else if (psel && penable && pwrite && paddr[2] == REG_STEP_SHIFT) begin
            step_shift_reg <= pwdata[SHF_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_STEP_SHIFT) ? APB_DW'(step_shift_reg) : '0;

    always_comb begin
        if (step_shift_reg < SHF_W'(1)) begin
            k_eff = 3'd1;
        end else if (step_shift_reg > SHF_W'(MAX_STEP_SHIFT)) begin
            k_eff = 3'(MAX_STEP_SHIFT);
        end else begin
            k_eff = step_shift_reg;
        end
    end

    ucbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .new_curve (s_data.new_curve),
        .k_eff     (k_eff),
        .stat      (stat),
        .cmd       (cmd)
    );

    ucbs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .k_eff   (k_eff),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ucbs_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_STEP_SHIFT = APB_AW'(4 * REG_STEP_SHIFT);
    // first address past the register list; writes there must be dropped
    localparam logic [APB_AW-1:0] ADDR_SPARE      = APB_AW'(4);
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    // Tracks the control point window and step_shift, and queues the
    // samples each accepted point should produce.
    class curve_tracker;
        sample_t               expected_samples[$];
        logic [COORD_BITS-1:0] win_x[3];
        logic [COORD_BITS-1:0] win_y[3];
        int                    held;
        int                    shift_reg;
        int                    errors;
        int                    points_seen;
        int                    segments;
        int                    samples_checked;

        function new();
            held            = 0;
            shift_reg       = RESET_SHIFT;
            errors          = 0;
            points_seen     = 0;
            segments        = 0;
            samples_checked = 0;
        endfunction

        function void write_shift(logic [APB_DW-1:0] value);
            shift_reg = int'(value[SHF_W-1:0]);
        endfunction

        // weighted sum over 6*N^3, rounded half up
        function longint mix(longint p[4], longint w[4], longint n3);
            longint acc;
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += p[j] * w[j];
            return (acc + 3 * n3) / (6 * n3);
        endfunction

        function void take_point(point_t p);
            int      k;
            longint  n;
            longint  n3;
            longint  m;
            longint  w[4];
            longint  px[4];
            longint  py[4];
            sample_t s;
            points_seen++;
            if (p.new_curve)
                held = 0;
            if (held < 3) begin
                win_x[held] = p.point_x;
                win_y[held] = p.point_y;
                held++;
                return;
            end
            k  = (shift_reg < 1) ? 1 : (shift_reg > MAX_STEP_SHIFT) ? MAX_STEP_SHIFT : shift_reg;
            n  = longint'(1) << k;
            n3 = n * n * n;
            px = '{longint'(win_x[0]), longint'(win_x[1]), longint'(win_x[2]),
                   longint'(p.point_x)};
            py = '{longint'(win_y[0]), longint'(win_y[1]), longint'(win_y[2]),
                   longint'(p.point_y)};
            for (longint i = 0; i <= n; i++) begin
                m    = n - i;
                w[0] = m * m * m;
                w[1] = 3 * i * i * i - 6 * n * i * i + 4 * n3;
                w[2] = -3 * i * i * i + 3 * n * i * i + 3 * n * n * i + n3;
                w[3] = i * i * i;
                s.curve_x = COORD_BITS'(mix(px, w, n3));
                s.curve_y = COORD_BITS'(mix(py, w, n3));
                s.last    = (i == n);
                expected_samples.push_back(s);
            end
            segments++;
            win_x[0] = win_x[1];
            win_x[1] = win_x[2];
            win_x[2] = p.point_x;
            win_y[0] = win_y[1];
            win_y[1] = win_y[2];
            win_y[2] = p.point_y;
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            samples_checked++;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample x=%0d y=%0d last=%0d", $time,
                         got.curve_x, got.curve_y, got.last);
                return;
            end
            want = expected_samples.pop_front();
            if (got.curve_x !== want.curve_x) begin
                errors++;
                $display("%0t: curve_x expected %0d actual %0d", $time,
                         want.curve_x, got.curve_x);
            end
            if (got.curve_y !== want.curve_y) begin
                errors++;
                $display("%0t: curve_y expected %0d actual %0d", $time,
                         want.curve_y, got.curve_y);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn    = 1'b0;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    point_t            s_data     = '0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    sample_t           m_data;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [APB_DW-1:0] pwdata     = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    curve_tracker board;
    int stall_pct   = 25;
    int rx_hold     = 0;
    int rx_run      = 0;
    int curve_left  = 0;
    int cycle_count = 0;
    int cfg_errors  = 0;

    int shift_plan[8] = '{1, 0, 7, 3, 6, 2, 4, 5};
    int item_plan[8]  = '{28, 20, 10, 20, 8, 10, 18, 12};

    uniform_cubic_bspline_evaluator_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d samples outstanding", $time,
                     board.expected_samples.size());
            $display("status: fail");
            $finish;
        end
    end

    // receiver: runs of ready/stall, plus one long hold on request
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_run == 0) begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
            rx_run  <= $urandom_range(0, 5);
        end else begin
            rx_run <= rx_run - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.take_point(s_data);
            if (m_valid && m_ready)
                board.check_sample(m_data);
        end
    end

    function automatic point_t make_point(int x, int y, bit nc);
        point_t p;
        p.point_x   = COORD_BITS'(x);
        p.point_y   = COORD_BITS'(y);
        p.new_curve = nc;
        return p;
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    // mostly well-formed curves of 4..12 points; a few stray restarts
    function automatic point_t next_random_point();
        point_t p;
        p.point_x = pick_coord();
        p.point_y = pick_coord();
        if (curve_left == 0) begin
            curve_left  = $urandom_range(4, 12);
            p.new_curve = ($urandom_range(0, 4) != 0);
        end else begin
            p.new_curve = ($urandom_range(0, 19) == 0);
        end
        curve_left--;
        return p;
    endfunction

    // valid stays high on return; caller lowers it
    task automatic drive_point(input point_t p);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic feed_random(input int n_items, input bit flood);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n_items) begin
            burst = flood ? n_items : $urandom_range(1, 8);
            for (int j = 0; j < burst && sent < n_items; j++) begin
                drive_point(next_random_point());
                sent++;
            end
            gap = (flood || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (board.expected_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_STEP_SHIFT)
            board.write_shift(data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_shift_reg(input int want);
        logic [APB_DW-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_STEP_SHIFT;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (data[SHF_W-1:0] !== SHF_W'(want)) begin
            cfg_errors++;
            $display("%0t: step_shift readback expected %0d actual %0d", $time,
                     want, data[SHF_W-1:0]);
        end
    endtask

    initial begin
        point_t            directed[$];
        logic [APB_DW-1:0] wdata;
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_shift_reg(RESET_SHIFT);

        // window fill, extremes, restart on a full window, restart mid-fill
        directed.push_back(make_point(0, 0, 0));
        directed.push_back(make_point(1023, 1023, 0));
        directed.push_back(make_point(0, 1023, 0));
        directed.push_back(make_point(1023, 0, 0));
        directed.push_back(make_point(1023, 1023, 0));
        directed.push_back(make_point(512, 5, 1));
        directed.push_back(make_point(1023, 1023, 0));
        directed.push_back(make_point(1023, 1023, 0));
        directed.push_back(make_point(1023, 1023, 0));
        directed.push_back(make_point(1023, 1023, 0));
        directed.push_back(make_point(0, 0, 1));
        directed.push_back(make_point(0, 0, 0));
        directed.push_back(make_point(0, 0, 0));
        directed.push_back(make_point(0, 0, 0));
        directed.push_back(make_point(700, 300, 1));
        directed.push_back(make_point(10, 20, 0));
        directed.push_back(make_point(30, 40, 1));
        directed.push_back(make_point(682, 341, 0));
        directed.push_back(make_point(341, 682, 0));
        foreach (directed[i])
            drive_point(directed[i]);
        s_valid <= 1'b0;
        wait_idle();

        // write to an unmapped address must leave step_shift alone
        apb_write(ADDR_SPARE, 32'h1);
        check_shift_reg(RESET_SHIFT);
        drive_point(make_point(1, 2, 0));
        drive_point(make_point(1022, 1021, 0));
        s_valid <= 1'b0;
        @(posedge aclk);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            wdata            = $urandom();
            wdata[SHF_W-1:0] = SHF_W'(shift_plan[ph]);
            apb_write(ADDR_STEP_SHIFT, wdata);
            check_shift_reg(shift_plan[ph]);
            stall_pct <= (ph == 3) ? 0 : $urandom_range(10, 60);
            if (ph == 5) begin
                // receiver holds off while the sender keeps offering words
                rx_hold <= HOLD_CYCLES;
                feed_random(12, 1'b1);
            end
            feed_random(item_plan[ph], 1'b0);
        end

        wait_idle();
        $display("covered %0d control points, %0d segments, %0d samples checked",
                 board.points_seen, board.segments, board.samples_checked);
        $display("step_shift 0..7 incl. clamped values, curve restarts, long output stall");
        if (board.errors + cfg_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ucbs_pkg.sv
rtl/ucbs_datapath.sv
rtl/ucbs_ctrl.sv
rtl/uniform_cubic_bspline_evaluator_core.sv
test/testbench.sv
